// ===== rtl/dfs_pkg.sv =====
// Shared types, constants and helpers for the delimited field splitter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dfs_pkg;

	localparam int LINE_BYTES  = 4096;
	localparam int DELIM_SLOTS = 8;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		REG_DELIM_BYTES     = 3'd0,
		REG_DELIM_USED      = 3'd1,
		REG_CHAR_LIMIT      = 3'd2,
		REG_FIELD_LIMIT     = 3'd3,
		REG_FIELD_LEN_LIMIT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] delim_bytes;
		logic [3:0]  delim_used;
		logic [12:0] char_limit;
		logic [7:0]  field_limit;
		logic [7:0]  field_len_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       field_closed;
		logic [7:0] field_num;
		logic       line_finished;
		logic [7:0] fields_total;
		logic       run_last;
	} result_t;

	function automatic logic is_white(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) ||
			(b == CH_VT) || (b == CH_FF) || (b == CH_CR);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dfs_cfg_regs.sv =====
// APB-style configuration registers of the field splitter.
// Depends on dfs_pkg for the register map and the configuration struct.
`default_nettype none

module dfs_cfg_regs
	import dfs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.delim_bytes     <= 64'(CH_SPACE);
			cfg.delim_used      <= 4'd1;
			cfg.char_limit      <= 13'(LINE_BYTES);
			cfg.field_limit     <= 8'd255;
			cfg.field_len_limit <= 8'd255;
		end else if (wr_en) begin
			case (idx)
				REG_DELIM_BYTES:     cfg.delim_bytes     <= pwdata;
				REG_DELIM_USED:      cfg.delim_used      <= pwdata[3:0];
				REG_CHAR_LIMIT:      cfg.char_limit      <= pwdata[12:0];
				REG_FIELD_LIMIT:     cfg.field_limit     <= pwdata[7:0];
				REG_FIELD_LEN_LIMIT: cfg.field_len_limit <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DELIM_BYTES:     prdata = cfg.delim_bytes;
			REG_DELIM_USED:      prdata = {60'd0, cfg.delim_used};
			REG_CHAR_LIMIT:      prdata = {51'd0, cfg.char_limit};
			REG_FIELD_LIMIT:     prdata = {56'd0, cfg.field_limit};
			REG_FIELD_LEN_LIMIT: prdata = {56'd0, cfg.field_len_limit};
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/dfs_core.sv =====
// Input register, line state and per-word split logic of the field splitter.
// Depends on dfs_pkg; emits zero, one or two results per word into the queue.
`default_nettype none

module dfs_core
	import dfs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  cfg_t            cfg,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       line_start,
	input  wire logic       room,
	output logic [1:0]      push_n,
	output result_t         res0,
	output result_t         res1
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        fire;

	logic [12:0] bytes_seen_q;
	logic [7:0]  field_count_q;
	logic [7:0]  chars_in_field_q;
	logic        line_over_q;

	logic [12:0] bs, bs_nx, lim;
	logic [7:0]  fc, fc_nx, fc1, cif, cif_nx, flim;
	logic        over, over_nx;
	logic [3:0]  used_n;
	logic        hit, spaces, delim, keep;
	logic [1:0]  n;

	assign fire     = valid_s1 & room;
	assign in_ready = ~valid_s1 | fire;
	assign push_n   = fire ? n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			start_s1 <= line_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q     <= '0;
			field_count_q    <= '0;
			chars_in_field_q <= '0;
			line_over_q      <= 1'b0;
		end else if (fire) begin
			bytes_seen_q     <= bs_nx;
			field_count_q    <= fc_nx;
			chars_in_field_q <= cif_nx;
			line_over_q      <= over_nx;
		end
	end

	// Delimiter match: one compare per slot; a space slot enables all white space.
	always_comb begin
		used_n = (cfg.delim_used > 4'(DELIM_SLOTS)) ? 4'(DELIM_SLOTS) : cfg.delim_used;
		hit    = 1'b0;
		spaces = 1'b0;
		for (int i = 0; i < DELIM_SLOTS; i++) begin
			if (4'(i) < used_n) begin
				if (cfg.delim_bytes[8*i +: 8] == byte_s1) hit = 1'b1;
				if (cfg.delim_bytes[8*i +: 8] == CH_SPACE) spaces = 1'b1;
			end
		end
		delim = hit | (spaces & is_white(byte_s1));
	end

	always_comb begin
		lim  = (cfg.char_limit > 13'(LINE_BYTES)) ? 13'(LINE_BYTES) : cfg.char_limit;
		flim = (cfg.field_limit == 8'd0) ? 8'd1 : cfg.field_limit;

		bs   = start_s1 ? '0 : bytes_seen_q;
		fc   = start_s1 ? '0 : field_count_q;
		cif  = start_s1 ? '0 : chars_in_field_q;
		over = start_s1 ? 1'b0 : line_over_q;

		bs_nx   = bs;
		fc_nx   = fc;
		cif_nx  = cif;
		over_nx = over;
		fc1     = fc + 8'd1;
		keep    = (cfg.field_len_limit != 8'd0) &&
			({1'b0, cif} + 9'd1 < {1'b0, cfg.field_len_limit});
		n       = 2'd0;
		res0    = '0;
		res1    = '0;

		if (over) begin
			n = 2'd0;
		end else if (byte_s1 == CH_NUL || byte_s1 == CH_NL || bs >= lim) begin
			// The line ends here without examining the word.
			n       = 2'd1;
			fc_nx   = fc1;
			over_nx = 1'b1;
			res0.field_closed  = 1'b1;
			res0.field_num     = fc;
			res0.line_finished = 1'b1;
			res0.fields_total  = fc1;
			res0.run_last      = 1'b1;
		end else begin
			bs_nx = bs + 13'd1;
			if (delim) begin
				cif_nx = '0;
				fc_nx  = fc1;
				res0.field_closed = 1'b1;
				res0.field_num    = fc;
				if (fc1 >= flim) begin
					n       = 2'd1;
					over_nx = 1'b1;
					res0.line_finished = 1'b1;
					res0.fields_total  = fc1;
					res0.run_last      = 1'b1;
				end else if (bs_nx >= lim) begin
					// The delimiter also exhausts the line, so the empty last field closes too.
					n       = 2'd2;
					fc_nx   = fc1 + 8'd1;
					over_nx = 1'b1;
					res1.field_closed  = 1'b1;
					res1.field_num     = fc1;
					res1.line_finished = 1'b1;
					res1.fields_total  = fc1 + 8'd1;
					res1.run_last      = 1'b1;
				end else begin
					n = 2'd1;
					res0.run_last = 1'b1;
				end
			end else begin
				n = 2'd1;
				if (keep) cif_nx = cif + 8'd1;
				res0.out_byte   = keep ? byte_s1 : 8'd0;
				res0.byte_valid = keep;
				res0.field_num  = fc;
				res0.run_last   = 1'b1;
				if (bs_nx >= lim) begin
					fc_nx   = fc1;
					over_nx = 1'b1;
					res0.field_closed  = 1'b1;
					res0.line_finished = 1'b1;
					res0.fields_total  = fc1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dfs_out_fifo.sv =====
// Small result queue that takes up to two results a cycle and hands out one.
// Depends on dfs_pkg for the result struct and the queue depth.
`default_nettype none

module dfs_out_fifo
	import dfs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_n,
	input  result_t         res0,
	input  result_t         res1,
	output logic            room,
	output logic            out_valid,
	input  wire logic       out_ready,
	output result_t         head
);

	result_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid & out_ready;
	// Room for a full two-result word, whatever the consumer does this cycle.
	assign room      = count_q <= FIFO_CW'(FIFO_DEPTH - 2);
	assign wr_ptr1   = wr_ptr_q + 1'b1;
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem[wr_ptr_q] <= res0;
		if (push_n == 2'd2) mem[wr_ptr1] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q  <= count_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/delimited_field_splitter.sv =====
// Top level of the delimited field splitter: registers, split core, result queue.
// Depends on dfs_pkg, dfs_cfg_regs, dfs_core and dfs_out_fifo.
//
// Channel  Dir  Handshake              Payload
// cfg      in   psel/penable/pready    paddr, pwdata, pwrite, prdata (64-bit regs at 8*i)
// in       in   in_valid/in_ready      in_byte, line_start
// out      out  out_valid/out_ready    out_byte, byte_valid, field_closed, field_num,
//                                      line_finished, fields_total, run_last
//
// A word is registered on acceptance and split from that register, one word per cycle
// while the result queue has room. Its results are pushed into the queue and leave
// from the queue head.
// A word that closes two fields puts two results into the queue; the four-entry
// result queue takes a new word whenever at least two entries are free.
// Reset restores the register defaults and starts a fresh line; no clearing pass.
`default_nettype none

module delimited_field_splitter
	import dfs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        in_byte,
	input  wire logic              line_start,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   byte_valid,
	output logic                   field_closed,
	output logic [7:0]             field_num,
	output logic                   line_finished,
	output logic [7:0]             fields_total,
	output logic                   run_last
);

	cfg_t       cfg;
	result_t    res0, res1, head;
	logic [1:0] push_n;
	logic       room;

	dfs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dfs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.line_start (line_start),
		.room       (room),
		.push_n     (push_n),
		.res0       (res0),
		.res1       (res1)
	);

	dfs_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.res0      (res0),
		.res1      (res1),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign out_byte      = head.out_byte;
	assign byte_valid    = head.byte_valid;
	assign field_closed  = head.field_closed;
	assign field_num     = head.field_num;
	assign line_finished = head.line_finished;
	assign fields_total  = head.fields_total;
	assign run_last      = head.run_last;

`ifndef NO_ASSERTIONS
	// The core only pushes when the queue has space for a full word.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> room)
		else $error("result pushed without queue room");

	// A two-result word is a delimiter closing a field and then the final field.
	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (res1.line_finished && res1.run_last &&
			!res0.line_finished && !res0.run_last && res1.field_num == res0.field_num + 8'd1))
		else $error("malformed two-result word");

	// A finished line always closes a field.
	a_finish_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_finished) |-> field_closed)
		else $error("line finished without a field close");
`endif

endmodule

`default_nettype wire

// ===== dv/field_split_checker.sv =====
// Checker for the delimited field splitter: follows register writes, predicts the
// results of every accepted word and compares them with the words that leave the block.
// Depends on dfs_pkg for the result layout, register indexes and character codes.
`timescale 1ns / 1ps

module field_split_checker
	import dfs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire logic [7:0]        in_byte,
	input  wire logic              line_start,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire logic [7:0]        out_byte,
	input  wire logic              byte_valid,
	input  wire logic              field_closed,
	input  wire logic [7:0]        field_num,
	input  wire logic              line_finished,
	input  wire logic [7:0]        fields_total,
	input  wire logic              run_last,
	output int                     fail_count,
	output int                     pending
);

	cfg_t    split_cfg;
	int      bytes_seen;
	int      field_count;
	int      chars_in_field;
	bit      line_over;
	int      errors;
	result_t splits_due[$];

	function automatic bit is_separator(input logic [7:0] b);
		int         n;
		bit         hit;
		bit         space_listed;
		logic [7:0] d;
		n = split_cfg.delim_used > DELIM_SLOTS ? DELIM_SLOTS : int'(split_cfg.delim_used);
		hit = 1'b0;
		space_listed = 1'b0;
		for (int i = 0; i < n; i++) begin
			d = split_cfg.delim_bytes[8*i +: 8];
			if (d == b)
				hit = 1'b1;
			if (d == CH_SPACE)
				space_listed = 1'b1;
		end
		// A listed space widens the set to every white-space character.
		return hit || (space_listed && (b == CH_SPACE || b == CH_TAB || b == CH_NL ||
			b == CH_VT || b == CH_FF || b == CH_CR));
	endfunction

	function automatic void queue_split(input logic [7:0] ob, input logic bv, input logic fc,
		input int fn, input logic lf, input int ft, input logic rl);
		result_t r;
		r.out_byte      = ob;
		r.byte_valid    = bv;
		r.field_closed  = fc;
		r.field_num     = 8'(fn);
		r.line_finished = lf;
		r.fields_total  = 8'(ft);
		r.run_last      = rl;
		splits_due.push_back(r);
	endfunction

	function automatic void split_word(input logic [7:0] b, input logic ls);
		int         lim;
		int         flim;
		int         fn;
		bit         keep;
		logic [7:0] kept;
		lim = split_cfg.char_limit > LINE_BYTES ? LINE_BYTES : int'(split_cfg.char_limit);
		flim = split_cfg.field_limit == 0 ? 1 : int'(split_cfg.field_limit);
		if (ls) begin
			bytes_seen = 0;
			field_count = 0;
			chars_in_field = 0;
			line_over = 1'b0;
		end
		if (line_over)
			return;
		if (b == CH_NUL || b == CH_NL || bytes_seen >= lim) begin
			fn = field_count;
			field_count++;
			line_over = 1'b1;
			queue_split(8'h00, 1'b0, 1'b1, fn, 1'b1, field_count, 1'b1);
			return;
		end
		bytes_seen++;
		if (is_separator(b)) begin
			fn = field_count;
			field_count++;
			chars_in_field = 0;
			if (field_count >= flim) begin
				line_over = 1'b1;
				queue_split(8'h00, 1'b0, 1'b1, fn, 1'b1, field_count, 1'b1);
			end else if (bytes_seen >= lim) begin
				// The separator used up the line, so the empty field after it closes too.
				queue_split(8'h00, 1'b0, 1'b1, fn, 1'b0, 0, 1'b0);
				fn = field_count;
				field_count++;
				line_over = 1'b1;
				queue_split(8'h00, 1'b0, 1'b1, fn, 1'b1, field_count, 1'b1);
			end else begin
				queue_split(8'h00, 1'b0, 1'b1, fn, 1'b0, 0, 1'b1);
			end
		end else begin
			keep = split_cfg.field_len_limit != 0 &&
				chars_in_field + 1 < int'(split_cfg.field_len_limit);
			kept = keep ? b : 8'h00;
			if (keep)
				chars_in_field++;
			fn = field_count;
			if (bytes_seen >= lim) begin
				field_count++;
				line_over = 1'b1;
				queue_split(kept, keep, 1'b1, fn, 1'b1, field_count, 1'b1);
			end else begin
				queue_split(kept, keep, 1'b0, fn, 1'b0, 0, 1'b1);
			end
		end
	endfunction

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			split_cfg.delim_bytes = 64'(CH_SPACE);
			split_cfg.delim_used = 4'd1;
			split_cfg.char_limit = 13'(LINE_BYTES);
			split_cfg.field_limit = 8'd255;
			split_cfg.field_len_limit = 8'd255;
			bytes_seen = 0;
			field_count = 0;
			chars_in_field = 0;
			line_over = 1'b0;
			errors = 0;
			splits_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:3]))
					REG_DELIM_BYTES:     split_cfg.delim_bytes = pwdata;
					REG_DELIM_USED:      split_cfg.delim_used = pwdata[3:0];
					REG_CHAR_LIMIT:      split_cfg.char_limit = pwdata[12:0];
					REG_FIELD_LIMIT:     split_cfg.field_limit = pwdata[7:0];
					REG_FIELD_LEN_LIMIT: split_cfg.field_len_limit = pwdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				split_word(in_byte, line_start);
			if (out_valid && out_ready) begin
				if (splits_due.size() == 0) begin
					$display("%0t ns: unexpected word, expected none, actual field_num %0d",
						$time, field_num);
					errors++;
				end else begin
					want = splits_due.pop_front();
					compare_field("out_byte", want.out_byte, out_byte);
					compare_field("byte_valid", want.byte_valid, byte_valid);
					compare_field("field_closed", want.field_closed, field_closed);
					compare_field("field_num", want.field_num, field_num);
					compare_field("line_finished", want.line_finished, line_finished);
					compare_field("fields_total", want.fields_total, fields_total);
					compare_field("run_last", want.run_last, run_last);
				end
			end
		end
		pending = splits_due.size();
		fail_count = errors;
	end

endmodule

// ===== dv/tb.sv =====
// Top of the delimited field splitter testbench: clock, reset, register writes,
// line stimulus and random back-pressure. Depends on dfs_pkg, the block and field_split_checker.
`timescale 1ns / 1ps

module tb;
	import dfs_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        in_byte;
	logic              line_start;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        out_byte;
	logic              byte_valid;
	logic              field_closed;
	logic [7:0]        field_num;
	logic              line_finished;
	logic [7:0]        fields_total;
	logic              run_last;

	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          words_sent;
	bit          in_calm;
	bit          out_calm;
	logic [63:0] delim_set;
	int          delim_count;

	delimited_field_splitter i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .line_start(line_start),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
		.byte_valid(byte_valid), .field_closed(field_closed), .field_num(field_num),
		.line_finished(line_finished), .fields_total(fields_total), .run_last(run_last)
	);

	field_split_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .line_start(line_start),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
		.byte_valid(byte_valid), .field_closed(field_closed), .field_num(field_num),
		.line_finished(line_finished), .fields_total(fields_total), .run_last(run_last),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Output side: a random stall before each word, none while out_calm is set.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = out_calm ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send_word(input logic [7:0] b, input logic ls);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		line_start <= ls;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drain the block: every predicted word out, then time for words that give none.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [63:0] bytes, input int used, input int chars,
		input int fields, input int field_len);
		quiesce();
		write_reg(REG_DELIM_BYTES, bytes);
		write_reg(REG_DELIM_USED, 64'(used));
		write_reg(REG_CHAR_LIMIT, 64'(chars));
		write_reg(REG_FIELD_LIMIT, 64'(fields));
		write_reg(REG_FIELD_LEN_LIMIT, 64'(field_len));
		delim_set = bytes;
		delim_count = used;
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		int n;
		n = delim_count > DELIM_SLOTS ? DELIM_SLOTS : delim_count;
		r = $urandom_range(0, 99);
		if (r < 25 && n > 0)
			return delim_set[8*$urandom_range(0, n - 1) +: 8];
		if (r < 33) begin
			case ($urandom_range(0, 4))
				0: return CH_SPACE;
				1: return CH_TAB;
				2: return CH_VT;
				3: return CH_FF;
				default: return CH_CR;
			endcase
		end
		if (r < 40)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	// One line of random content, usually closed by a newline or NUL, now and then
	// followed by stray words that the finished line has to ignore.
	task automatic send_line(input int len);
		int r;
		in_calm = ($urandom_range(0, 3) == 0);
		out_calm = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++)
			send_word(pick_byte(), (i == 0) || ($urandom_range(0, 49) == 0));
		r = $urandom_range(0, 19);
		if (r < 12)
			send_word(CH_NL, len == 0);
		else if (r < 17 || len == 0)
			send_word(CH_NUL, len == 0);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) send_word(pick_byte(), 1'b0);
	endtask

	task automatic run_lines(input int budget, input int max_len);
		int start;
		start = words_sent;
		while (words_sent - start < budget)
			send_line($urandom_range(0, max_len));
	endtask

	initial begin
		logic [63:0] mix;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		line_start = 1'b0;
		in_calm = 1'b0;
		out_calm = 1'b0;
		delim_set = 64'(CH_SPACE);
		delim_count = 1;
		words_sent = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset setting: the space delimiter makes all white space split fields.
		// The first line has no line start at all.
		send_word(8'h61, 1'b0);
		send_word(CH_SPACE, 1'b0);
		send_word(CH_SPACE, 1'b0);
		send_word(CH_TAB, 1'b0);
		send_word(8'h62, 1'b0);
		send_word(CH_CR, 1'b0);
		send_word(CH_VT, 1'b0);
		send_word(CH_FF, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(CH_NUL, 1'b0);
		send_word(8'h78, 1'b0);
		send_word(8'h7F, 1'b1);
		send_word(8'h01, 1'b0);
		send_word(CH_SPACE, 1'b0);
		send_word(CH_NL, 1'b0);
		send_word(CH_NL, 1'b1);

		// Comma and semicolon separated text.
		apply_setting({48'h0, 8'h3B, 8'h2C}, 2, LINE_BYTES, 255, 255);
		run_lines(90, 12);

		// Every slot in use, all limits at one.
		mix = {$urandom, $urandom};
		mix[31:24] = CH_SPACE;
		apply_setting(mix, DELIM_SLOTS, 1, 1, 1);
		run_lines(40, 4);

		// No delimiters and zero limits: the first word ends each line.
		apply_setting(64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0);
		run_lines(30, 4);

		// Slot count past the slot total and a character limit past the line buffer.
		apply_setting({8'hFF, 8'h2C, 8'h00, 8'h3A, 8'h7C, 8'h09, 8'h2E, 8'h20}, 15, 8191, 4, 3);
		run_lines(90, 10);

		// One field longer than the keep limit, cut off by the character limit.
		apply_setting({$urandom, $urandom}, 0, 300, 255, 255);
		send_line(310);

		repeat (5) begin
			mix = {$urandom, $urandom};
			if ($urandom_range(0, 1))
				mix[7:0] = CH_SPACE;
			apply_setting(mix, $urandom_range(0, 9),
				$urandom_range(0, 3) == 0 ? $urandom_range(1, 8191) : $urandom_range(1, 30),
				$urandom_range(0, 2) == 0 ? 255 : $urandom_range(1, 12),
				$urandom_range(0, 2) == 0 ? 255 : $urandom_range(0, 12));
			run_lines(40, 16);
		end

		quiesce();
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
